>>> src/bsoc_pkg.sv
// Shared types and constants for the battery state-of-charge estimator.
// Holds field widths, register indexes, the open-circuit curve and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package bsoc_pkg;

   // Field widths
   localparam int VOLT_W     = 16;
   localparam int CUR_W      = 19;
   localparam int TIME_W     = 16;
   localparam int CAP_W      = 16;
   localparam int IDLE_W     = 18;
   localparam int WEIGHT_W   = 16;
   localparam int SOC_W      = 23;
   localparam int MAG_W      = 19;

   // Stream and register port widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_IDX_W  = 2;

   // Request field offsets inside req_tdata
   localparam int REQ_VOLT_LSB = 0;
   localparam int REQ_CUR_LSB  = VOLT_W;
   localparam int REQ_TIME_LSB = VOLT_W + CUR_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT   = 2'd2;

   // Register reset values
   localparam logic [CAP_W-1:0]    CAP_RESET    = 16'd2000;
   localparam logic [IDLE_W-1:0]   IDLE_RESET   = 18'd10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd1311;

   // Coulomb counting: uA * ms per percent per mAh
   localparam int COULOMB_W = 26;
   localparam logic [COULOMB_W-1:0] COULOMB_SCALE = 26'd36000000;

   // Shared divider operand widths
   localparam int DIVIDEND_W = 34;
   localparam int DIVISOR_W  = 42;

   // Open-circuit curve, 0 % to 100 % in steps of 10 %
   localparam int OCV_PTS   = 11;
   localparam int SEG_W     = 4;
   localparam int OCV_NUM_W = 12;
   localparam int OCV_DEN_W = 9;
   localparam int PCT_W     = 7;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [3:0]       PCT_SEG  = 4'd10;

   typedef logic [VOLT_W-1:0] mv_type;

   localparam mv_type OCV_BP [0:OCV_PTS-1] = '{
      16'd6000, 16'd6400, 16'd6700, 16'd6900, 16'd7100, 16'd7300,
      16'd7500, 16'd7700, 16'd7900, 16'd8100, 16'd8400
   };

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic div_ocv;
      logic add_delta;
      logic set_target;
      logic init_accum;
      logic diff;
      logic mul_lo;
      logic mul_hi;
      logic apply;
      logic clamp;
      logic emit;
   } bsoc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic first;
      logic idle;
      logic sat;
      logic div_done;
      logic div_busy;
      logic out_free;
   } bsoc_stat_type;

endpackage

>>> src/bsoc_divider.sv
// Bit-serial restoring divider: round(dividend * 2^FRAC_BITS / divisor),
// one quotient bit per cycle, halves rounded up. Depends on bsoc_pkg.
`timescale 1ns / 1ps

module bsoc_divider #(
   parameter int FRAC_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bsoc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [bsoc_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              busy,
   output logic                              done,
   output logic [FRAC_BITS+9:0]              quotient
);
   import bsoc_pkg::*;

   localparam int QW = DIVIDEND_W + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);
   localparam int RW = FRAC_BITS + 10;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [RW-1:0]         res_ff, res_in;

   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  fits;
   logic                  round_up;
   logic [QW-1:0]         quo_round;
   logic                  last;

   // One restoring step and the final rounding
   assign rem_sh    = {rem_ff, quo_ff[QW-1]};
   assign fits      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub   = rem_sh - {1'b0, dsr_ff};
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, dsr_ff};
   assign quo_round = quo_ff + QW'(round_up);
   assign last      = cnt_ff == CW'(QW);

   // Sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = {dividend, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!last) begin
            rem_in = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[QW-2:0], fits};
            cnt_in = cnt_ff + CW'(1);
         end else begin
            res_in  = quo_round[RW-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      res_ff <= res_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

>>> src/bsoc_ctrl.sv
// Controller state machine for the state-of-charge estimator.
// Sequences the datapath by commands; reads its status. Depends on bsoc_pkg.
`timescale 1ns / 1ps

module bsoc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  bsoc_pkg::bsoc_stat_type stat,
   output bsoc_pkg::bsoc_cmd_type  cmd
);
   import bsoc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PREP  = 4'd1;
   localparam logic [3:0] S_CDIV  = 4'd2;
   localparam logic [3:0] S_CWAIT = 4'd3;
   localparam logic [3:0] S_ODIV  = 4'd4;
   localparam logic [3:0] S_OWAIT = 4'd5;
   localparam logic [3:0] S_TGT   = 4'd6;
   localparam logic [3:0] S_INIT  = 4'd7;
   localparam logic [3:0] S_DIFF  = 4'd8;
   localparam logic [3:0] S_MLO   = 4'd9;
   localparam logic [3:0] S_MHI   = 4'd10;
   localparam logic [3:0] S_APPLY = 4'd11;
   localparam logic [3:0] S_CLAMP = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.first ? S_ODIV : S_CDIV;
         end
         S_CDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_CWAIT;
         end
         S_CWAIT: begin
            if (stat.div_done) begin
               cmd.add_delta = 1'b1;
               state_in      = stat.idle ? S_ODIV : S_CLAMP;
            end
         end
         S_ODIV: begin
            // off either end of the curve the target needs no division
            if (stat.sat) begin
               state_in = S_TGT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_ocv   = 1'b1;
               state_in      = S_OWAIT;
            end
         end
         S_OWAIT: begin
            if (stat.div_done) begin
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            cmd.set_target = 1'b1;
            state_in       = stat.first ? S_INIT : S_DIFF;
         end
         S_INIT: begin
            cmd.init_accum = 1'b1;
            state_in       = S_OUT;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/bsoc_datapath.sv
// Datapath of the state-of-charge estimator: registers, curve lookup,
// charge accumulator, blend multiplier and response register.
// Depends on bsoc_pkg and bsoc_divider.
`timescale 1ns / 1ps

module bsoc_datapath #(
   parameter int FRAC_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsoc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [bsoc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  bsoc_pkg::bsoc_cmd_type            cmd,
   output bsoc_pkg::bsoc_stat_type           stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsoc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [bsoc_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import bsoc_pkg::*;

   localparam int AW = FRAC_BITS + 11;   // signed accumulator before clamp
   localparam int TW = FRAC_BITS + 7;    // curve target, 0..100 %
   localparam int RW = FRAC_BITS + 10;   // divider result
   localparam int MW = FRAC_BITS + 10;   // blend difference magnitude

   localparam logic [TW-1:0] FULL_SCALE = {PCT_FULL, {FRAC_BITS{1'b0}}};
   localparam logic signed [AW-1:0] FULL_ACC = {{(AW-TW){1'b0}}, FULL_SCALE};

   // Configuration
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [IDLE_W-1:0]   idle_lim_ff, idle_lim_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;

   // Request and prepared operands
   logic [VOLT_W-1:0]     volt_ff, volt_in;
   logic [CUR_W-1:0]      cur_ff, cur_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic                  neg_ff, neg_in;
   logic                  quiet_ff, quiet_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;
   logic [DIVISOR_W-1:0]  cden_ff, cden_in;
   logic [SEG_W-1:0]      seg_ff, seg_in;
   logic [OCV_NUM_W-1:0]  onum_ff, onum_in;
   logic [OCV_DEN_W-1:0]  oden_ff, oden_in;
   logic                  sat_hi_ff, sat_hi_in;
   logic                  sat_lo_ff, sat_lo_in;

   // Estimator state and working registers
   logic                  init_ff, init_in;
   logic                  first_ff, first_in;
   logic                  applied_ff, applied_in;
   logic signed [AW-1:0]  accum_ff, accum_in;
   logic [TW-1:0]         target_ff, target_in;
   logic                  down_ff, down_in;
   logic [MW-1:0]         dmag_ff, dmag_in;
   logic [15:0]           lo_ff, lo_in;
   logic [MW-1:0]         step_ff, step_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SOC_W-1:0]      rsp_soc_ff, rsp_soc_in;
   logic                  rsp_first_ff, rsp_first_in;
   logic                  rsp_applied_ff, rsp_applied_in;

   // Combinational helpers
   logic [MAG_W-1:0]        mag_c;
   logic [MAG_W+TIME_W-1:0] prod_c;
   logic [CAP_W-1:0]        cap_eff_c;
   logic [SEG_W-1:0]        seg_c;
   logic [SEG_W-1:0]        seg_nx_c;
   logic [VOLT_W-1:0]       ofs_c;
   logic [VOLT_W-1:0]       span_c;
   logic [PCT_W-1:0]        seg_pct_c;
   logic signed [AW-1:0]    delta_s;
   logic signed [AW-1:0]    step_s;
   logic signed [AW-1:0]    diff_c;
   logic [AW-1:0]           dabs_c;
   logic [31:0]             lo_prod_c;
   logic [31:0]             lo_sum_c;
   logic [MW-1:0]           hi_prod_c;

   logic                    div_busy;
   logic                    div_done;
   logic [RW-1:0]           div_res;
   logic [DIVIDEND_W-1:0]   div_dividend;
   logic [DIVISOR_W-1:0]    div_divisor;

   // Current magnitude, charge product and capacity divisor
   assign mag_c     = cur_ff[CUR_W-1] ? (~cur_ff + MAG_W'(1)) : cur_ff;
   assign prod_c    = mag_c * time_ff;
   assign cap_eff_c = (cap_ff == '0) ? CAP_W'(1) : cap_ff;

   // Curve segment: highest breakpoint strictly below the voltage
   always_comb begin
      seg_c = '0;
      for (int k = 1; k < OCV_PTS - 1; k++) begin
         if (volt_ff > OCV_BP[k]) begin
            seg_c = SEG_W'(k);
         end
      end
   end

   assign seg_nx_c  = seg_c + SEG_W'(1);
   assign ofs_c     = volt_ff - OCV_BP[seg_c];
   assign span_c    = OCV_BP[seg_nx_c] - OCV_BP[seg_c];
   assign seg_pct_c = PCT_W'(seg_ff) * PCT_W'(PCT_SEG);

   // Accumulator arithmetic
   assign delta_s   = signed'({1'b0, div_res});
   assign step_s    = signed'({1'b0, step_ff});
   assign diff_c    = signed'({{(AW-TW){1'b0}}, target_ff}) - accum_ff;
   assign dabs_c    = diff_c[AW-1] ? (~diff_c + AW'(1)) : diff_c;
   assign lo_prod_c = dmag_ff[15:0] * weight_ff;
   assign lo_sum_c  = lo_prod_c + 32'h0000_8000;
   assign hi_prod_c = dmag_ff[MW-1:16] * weight_ff;

   // Divider operand select
   assign div_dividend = cmd.div_ocv ? DIVIDEND_W'(onum_ff) : prod_ff;
   assign div_divisor  = cmd.div_ocv ? DIVISOR_W'(oden_ff) : cden_ff;

   bsoc_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_res)
   );

   // Next-state logic
   always_comb begin
      cap_in         = cap_ff;
      idle_lim_in    = idle_lim_ff;
      weight_in      = weight_ff;
      volt_in        = volt_ff;
      cur_in         = cur_ff;
      time_in        = time_ff;
      neg_in         = neg_ff;
      quiet_in       = quiet_ff;
      prod_in        = prod_ff;
      cden_in        = cden_ff;
      seg_in         = seg_ff;
      onum_in        = onum_ff;
      oden_in        = oden_ff;
      sat_hi_in      = sat_hi_ff;
      sat_lo_in      = sat_lo_ff;
      init_in        = init_ff;
      first_in       = first_ff;
      applied_in     = applied_ff;
      accum_in       = accum_ff;
      target_in      = target_ff;
      down_in        = down_ff;
      dmag_in        = dmag_ff;
      lo_in          = lo_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_soc_in     = rsp_soc_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_applied_in = rsp_applied_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_in      = csr_wdata[CAP_W-1:0];
            CSR_IDLE:     idle_lim_in = csr_wdata[IDLE_W-1:0];
            CSR_WEIGHT:   weight_in   = csr_wdata[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end

      // capture request
      if (cmd.load) begin
         volt_in    = req_tdata[REQ_VOLT_LSB +: VOLT_W];
         cur_in     = req_tdata[REQ_CUR_LSB +: CUR_W];
         time_in    = req_tdata[REQ_TIME_LSB +: TIME_W];
         first_in   = !init_ff;
         applied_in = 1'b0;
      end

      // operands for both divisions and the idle test
      if (cmd.prep) begin
         neg_in    = cur_ff[CUR_W-1];
         quiet_in  = mag_c < {1'b0, idle_lim_ff};
         prod_in   = prod_c[DIVIDEND_W-1:0];
         cden_in   = COULOMB_SCALE * cap_eff_c;
         seg_in    = seg_c;
         onum_in   = OCV_NUM_W'(ofs_c[OCV_DEN_W-1:0]) * OCV_NUM_W'(PCT_SEG);
         oden_in   = span_c[OCV_DEN_W-1:0];
         sat_hi_in = volt_ff >= OCV_BP[OCV_PTS-1];
         sat_lo_in = volt_ff <= OCV_BP[0];
      end

      // counted charge
      if (cmd.add_delta) begin
         accum_in = neg_ff ? (accum_ff - delta_s) : (accum_ff + delta_s);
      end

      // curve target
      if (cmd.set_target) begin
         if (sat_hi_ff) begin
            target_in = FULL_SCALE;
         end else if (sat_lo_ff) begin
            target_in = '0;
         end else begin
            target_in = {seg_pct_c, {FRAC_BITS{1'b0}}} + div_res[TW-1:0];
         end
      end

      // first sample: charge straight from the curve
      if (cmd.init_accum) begin
         accum_in = signed'({{(AW-TW){1'b0}}, target_ff});
         init_in  = 1'b1;
      end

      // blend toward the target
      if (cmd.diff) begin
         down_in = diff_c[AW-1];
         dmag_in = dabs_c[MW-1:0];
      end
      if (cmd.mul_lo) begin
         lo_in = lo_sum_c[31:16];
      end
      if (cmd.mul_hi) begin
         step_in = hi_prod_c + MW'(lo_ff);
      end
      if (cmd.apply) begin
         accum_in   = down_ff ? (accum_ff - step_s) : (accum_ff + step_s);
         applied_in = 1'b1;
      end

      // clamp to 0..100 %
      if (cmd.clamp) begin
         if (accum_ff[AW-1]) begin
            accum_in = '0;
         end else if (accum_ff > FULL_ACC) begin
            accum_in = FULL_ACC;
         end
      end

      // response register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_soc_in     = accum_ff[FRAC_BITS+6 -: SOC_W];
         rsp_first_in   = first_ff;
         rsp_applied_in = applied_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         idle_lim_ff  <= IDLE_RESET;
         weight_ff    <= WEIGHT_RESET;
         init_ff      <= 1'b0;
         accum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         idle_lim_ff  <= idle_lim_in;
         weight_ff    <= weight_in;
         init_ff      <= init_in;
         accum_ff     <= accum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      volt_ff        <= volt_in;
      cur_ff         <= cur_in;
      time_ff        <= time_in;
      neg_ff         <= neg_in;
      quiet_ff       <= quiet_in;
      prod_ff        <= prod_in;
      cden_ff        <= cden_in;
      seg_ff         <= seg_in;
      onum_ff        <= onum_in;
      oden_ff        <= oden_in;
      sat_hi_ff      <= sat_hi_in;
      sat_lo_ff      <= sat_lo_in;
      first_ff       <= first_in;
      applied_ff     <= applied_in;
      target_ff      <= target_in;
      down_ff        <= down_in;
      dmag_ff        <= dmag_in;
      lo_ff          <= lo_in;
      step_ff        <= step_in;
      rsp_soc_ff     <= rsp_soc_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_applied_ff <= rsp_applied_in;
   end

   // Status and outputs
   assign stat.first    = first_ff;
   assign stat.idle     = quiet_ff;
   assign stat.sat      = sat_hi_ff | sat_lo_ff;
   assign stat.div_done = div_done;
   assign stat.div_busy = div_busy;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-SOC_W){1'b0}}, rsp_soc_ff};
   assign rsp_tuser  = {rsp_applied_ff, rsp_first_ff};

endmodule

>>> src/battery_soc_coulomb_ocv_estimator.sv
// Battery state-of-charge estimator for a 2S Li-ion pack: one request in
// (voltage, current, elapsed time), one state-of-charge response out. The
// first request after reset sets the charge from the open-circuit curve;
// later ones add counted charge and, while the current is below the idle
// limit, blend toward the curve value, then clamp to 0..100 %. Requests are
// handled one at a time. Each division goes one quotient bit per cycle
// through the shared serial divider: later requests divide for the counted
// charge, and a first request or the idle blend divides for the curve
// value; a voltage off either end of the curve needs no curve division.
// A new request is taken while the previous response waits.
`timescale 1ns / 1ps

module battery_soc_coulomb_ocv_estimator #(
   parameter int ACCUM_FRAC_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // register write port
   input  logic                               csr_we,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsoc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // bus_voltage_mv [15:0], current_ua [34:16], elapsed_ms [50:35], zero [55:51]
   input  logic [bsoc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // soc_q16 [22:0], zero [23]
   output logic [bsoc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // was_first [0], ocv_applied [1]
   output logic [bsoc_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import bsoc_pkg::*;

   bsoc_cmd_type  cmd;
   bsoc_stat_type stat;

   bsoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bsoc_datapath #(
      .FRAC_BITS (ACCUM_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // one request at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in progress");

   // divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider started while busy");

   // a response is never overwritten before it is taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten while pending");

   // the curve-initialized sample never reports a blend
   a_first_no_blend: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> !rsp_tuser[1])
      else $error("first sample flagged as blended");
`endif

endmodule

>>> sim/tb_battery_soc_coulomb_ocv_estimator.sv
// Self-checking testbench for battery_soc_coulomb_ocv_estimator.
// It predicts each state-of-charge response in fixed point, drives random and
// directed requests with random flow control, and needs src/bsoc_pkg.sv and the RTL.
`timescale 1ns / 1ps

module tb_battery_soc_coulomb_ocv_estimator;
   import bsoc_pkg::*;

   localparam int FRAC_BITS     = 32;
   localparam longint FULL_SCALE = longint'(100) << FRAC_BITS;
   localparam int SETTLE_CYCLES = 200;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 110;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Open-circuit curve knees, 0 % to 100 % in 10 % steps
   localparam int KNEE_MV [0:10] = '{
      6000, 6400, 6700, 6900, 7100, 7300, 7500, 7700, 7900, 8100, 8400
   };

   typedef struct {
      logic [SOC_W-1:0] soc;
      logic             first;
      logic             applied;
   } soc_reading_type;

   // Tracks charge state and registers, queues the expected responses
   class soc_tracker_type;
      logic [CAP_W-1:0]    capacity_mah;
      logic [IDLE_W-1:0]   idle_ua;
      logic [WEIGHT_W-1:0] weight_q16;
      bit                  seeded;
      longint              charge;      // percent, Q7.32
      soc_reading_type     expected_soc_q[$];
      int                  mismatches;

      function new();
         capacity_mah = 16'd2000;
         idle_ua      = 18'd10000;
         weight_q16   = 16'd1311;
         seeded       = 1'b0;
         charge       = '0;
         mismatches   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CAPACITY: capacity_mah = val[CAP_W-1:0];
            CSR_IDLE:     idle_ua      = val[IDLE_W-1:0];
            CSR_WEIGHT:   weight_q16   = val[WEIGHT_W-1:0];
            default: ;    // unmapped index, write dropped
         endcase
      endfunction

      // Curve value in Q7.32; a knee voltage belongs to the segment below
      function longint curve_charge(logic [VOLT_W-1:0] mv);
         int seg;
         longint unsigned num, den;
         if (mv >= KNEE_MV[10]) return FULL_SCALE;
         if (mv <= KNEE_MV[0]) return '0;
         seg = 0;
         for (int k = 1; k < 10; k++)
            if (mv > KNEE_MV[k]) seg = k;
         num = longint'((mv - KNEE_MV[seg]) * 10) << FRAC_BITS;
         den = 64'(KNEE_MV[seg + 1] - KNEE_MV[seg]);
         return (longint'(seg * 10) << FRAC_BITS) + longint'((num + den / 2) / den);
      endfunction

      // |I| * t * 2^32 / (36e6 * capacity), nearest, halves up
      function longint unsigned coulomb_delta(longint unsigned mag, longint unsigned ms);
         bit [127:0] num, den;
         den = 128'd36000000 * 128'((capacity_mah == 0) ? 16'd1 : capacity_mah);
         num = 128'(mag * ms) << FRAC_BITS;
         return 64'((2 * num + den) / (2 * den));
      endfunction

      function void note_request(logic [VOLT_W-1:0] mv, logic signed [CUR_W-1:0] ua,
                                 logic [TIME_W-1:0] ms);
         soc_reading_type exp;
         longint unsigned mag, diff, pull, delta;
         longint          target;
         bit              down;
         exp.first   = 1'b0;
         exp.applied = 1'b0;
         mag = ua[CUR_W-1] ? 64'(-longint'(ua)) : 64'(longint'(ua));
         if (!seeded) begin
            charge    = curve_charge(mv);
            seeded    = 1'b1;
            exp.first = 1'b1;
         end else begin
            delta  = coulomb_delta(mag, ms);
            charge = ua[CUR_W-1] ? charge - longint'(delta) : charge + longint'(delta);
            // idle: blend toward the curve, rounded half away from zero
            if (mag < idle_ua) begin
               target = curve_charge(mv);
               down   = target < charge;
               diff   = down ? 64'(charge - target) : 64'(target - charge);
               pull   = (diff * weight_q16 + 64'd32768) >> 16;
               charge = down ? charge - longint'(pull) : charge + longint'(pull);
               exp.applied = 1'b1;
            end
            if (charge > FULL_SCALE) charge = FULL_SCALE;
            if (charge < 0) charge = '0;
         end
         exp.soc = SOC_W'(charge >>> (FRAC_BITS - 16));
         expected_soc_q.push_back(exp);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data,
                                   logic [RSP_USER_W-1:0] user);
         soc_reading_type exp;
         if (expected_soc_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual soc_q16 %0d",
                     $time, data[SOC_W-1:0]);
            mismatches++;
            return;
         end
         exp = expected_soc_q.pop_front();
         if (data[SOC_W-1:0] !== exp.soc) begin
            $display("%0t: soc_q16 expected %0d actual %0d", $time, exp.soc,
                     data[SOC_W-1:0]);
            mismatches++;
         end
         if (user[0] !== exp.first) begin
            $display("%0t: was_first expected %0b actual %0b", $time, exp.first, user[0]);
            mismatches++;
         end
         if (user[1] !== exp.applied) begin
            $display("%0t: ocv_applied expected %0b actual %0b", $time, exp.applied,
                     user[1]);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_soc_q.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;

   soc_tracker_type tracker = new();
   bit         req_steady = 1'b0;
   bit         rsp_steady = 1'b0;
   int         rsp_hold = 0;
   int         rsp_roll;
   int         cycles = 0;

   battery_soc_coulomb_ocv_estimator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("tb_battery_soc_coulomb_ocv_estimator: done, errors");
         $finish;
      end
   end

   // Response back-pressure: short and long stalls, or none in steady stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (rsp_steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 3)
            rsp_hold <= $urandom_range(15, 60);
         else if (rsp_roll < 20)
            rsp_hold <= $urandom_range(1, 4);
         rsp_tready <= (rsp_roll >= 20);
      end
   end

   // Handshake monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tdata[REQ_VOLT_LSB +: VOLT_W],
                                 req_tdata[REQ_CUR_LSB +: CUR_W],
                                 req_tdata[REQ_TIME_LSB +: TIME_W]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_response(rsp_tdata, rsp_tuser);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (req_steady || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_request(input logic [VOLT_W-1:0] mv,
                               input logic signed [CUR_W-1:0] ua,
                               input logic [TIME_W-1:0] ms);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, ms, ua, mv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random request: mostly pack-range voltages; currents often near the idle limit
   task automatic random_request();
      int                      roll;
      int                      span, mag;
      logic [VOLT_W-1:0]       mv;
      logic signed [CUR_W-1:0] ua;
      logic [TIME_W-1:0]       ms;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         mv = VOLT_W'($urandom_range(5900, 8500));
      else if (roll < 85)
         mv = VOLT_W'($urandom_range(0, 40960));
      else
         mv = VOLT_W'(KNEE_MV[$urandom_range(0, 10)] + int'($urandom_range(0, 2)) - 1);

      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         span = (tracker.idle_ua == 0) ? 1000 :
                int'(tracker.idle_ua) + int'(tracker.idle_ua) / 4;
         if (span > 262143) span = 262143;
         mag = int'($urandom_range(0, span));
         ua  = CUR_W'(mag);
         if ($urandom_range(0, 1)) ua = -ua;
      end else if (roll < 80) begin
         ua = CUR_W'($urandom);
      end else if (roll < 90) begin
         case ($urandom_range(0, 3))
            0: ua = 19'h40000;
            1: ua = 19'sd262143;
            2: ua = CUR_W'(tracker.idle_ua);
            default: ua = (tracker.idle_ua == 0) ? '0 : CUR_W'(tracker.idle_ua - 1);
         endcase
         if ($urandom_range(0, 1) && ua != 19'h40000) ua = -ua;
      end else begin
         ua = '0;
      end

      roll = $urandom_range(0, 99);
      if (roll < 50)
         ms = TIME_W'($urandom_range(0, 2000));
      else if (roll < 85)
         ms = TIME_W'($urandom);
      else
         ms = $urandom_range(0, 1) ? 16'd65535 : 16'd0;
      send_request(mv, ua, ms);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.set_reg(idx, val);
   endtask

   // Also hits the unmapped index, which must change nothing
   task automatic load_settings(input logic [CSR_DATA_W-1:0] cap,
                                input logic [CSR_DATA_W-1:0] idle,
                                input logic [CSR_DATA_W-1:0] wt);
      write_reg(CSR_CAPACITY, cap);
      write_reg(CSR_IDLE, idle);
      write_reg(CSR_WEIGHT, wt);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Drain all responses, then let the block go fully idle
   task automatic settle();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset register values: first sample ignores current and time
      send_request(16'd7000, 19'h40000, 16'd65535);
      send_request(16'd6000, 19'sd0, 16'd0);
      send_request(16'd8400, 19'sd5, 16'd1000);
      send_request(16'd40960, 19'sd9999, 16'd65535);
      send_request(16'd0, -19'sd9999, 16'd100);
      send_request(16'd6400, 19'sd10000, 16'd1000);
      send_request(16'd6401, -19'sd10000, 16'd1000);
      send_request(16'd8399, 19'sd262143, 16'd65535);
      for (int k = 2; k < 10; k++)
         send_request(VOLT_W'(KNEE_MV[k]), 19'sd0, 16'd0);
      send_request(16'd6001, 19'h40000, 16'd65535);
      send_request(16'd32768, -19'sd1, 16'd1);
      send_request(16'd16383, 19'sd1, 16'd32768);
      send_request(16'd7350, 19'sd200000, 16'd0);
      req_tvalid <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: load_settings(18'd0, 18'd262143, 18'd65535);
            1: load_settings(18'd65535, 18'd0, 18'd0);
            2: load_settings(18'd1, 18'd5000, 18'd32768);
            3: load_settings(18'h30BB8, 18'd20000, 18'h31311);
            default: load_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                   CSR_DATA_W'($urandom));
         endcase
         // Zero capacity counts as 1 mAh: full-scale swings, clamps at both ends,
         // and the most negative current is never idle even at the top limit
         if (ph == 0) begin
            send_request(16'd7000, 19'sd262143, 16'd65535);
            send_request(16'd7000, 19'h40000, 16'd65535);
            send_request(16'd7000, 19'sd262142, 16'd100);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               req_steady = ($urandom_range(0, 3) == 0);
               rsp_steady = ($urandom_range(0, 3) == 0);
            end
            random_request();
         end
         req_tvalid <= 1'b0;
      end

      settle();
      if (tracker.mismatches == 0)
         $display("tb_battery_soc_coulomb_ocv_estimator: done, clean");
      else
         $display("tb_battery_soc_coulomb_ocv_estimator: done, errors");
      $finish;
   end

endmodule
